/* src/segment_intersection_assert.svh */
// assertion macros used by segment_intersection
`ifndef SEGMENT_INTERSECTION_ASSERT_SVH
`define SEGMENT_INTERSECTION_ASSERT_SVH
`ifndef SYNTHESIS
`define SI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("segment_intersection: assertion failed");
`define SI_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("segment_intersection: assertion failed");
`else
`define SI_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SI_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* src/sis_pkg.sv */
package sis_pkg;
    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int OUT_BITS       = 32;
endpackage

/* src/sis_seg_if.sv */
interface sis_seg_if #(
    parameter int COORD_BITS = sis_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] seg1_start_x;
    logic signed [COORD_BITS-1:0] seg1_start_y;
    logic signed [COORD_BITS-1:0] seg1_end_x;
    logic signed [COORD_BITS-1:0] seg1_end_y;
    logic signed [COORD_BITS-1:0] seg2_start_x;
    logic signed [COORD_BITS-1:0] seg2_start_y;
    logic signed [COORD_BITS-1:0] seg2_end_x;
    logic signed [COORD_BITS-1:0] seg2_end_y;

    modport source (
        output valid, seg1_start_x, seg1_start_y, seg1_end_x, seg1_end_y,
               seg2_start_x, seg2_start_y, seg2_end_x, seg2_end_y,
        input  ready
    );
    modport sink (
        input  valid, seg1_start_x, seg1_start_y, seg1_end_x, seg1_end_y,
               seg2_start_x, seg2_start_y, seg2_end_x, seg2_end_y,
        output ready
    );
endinterface

/* src/sis_cross_if.sv */
interface sis_cross_if;
    logic                                valid;
    logic                                ready;
    logic                                hit;
    logic signed [sis_pkg::OUT_BITS-1:0] cross_x;
    logic signed [sis_pkg::OUT_BITS-1:0] cross_y;

    modport source (output valid, hit, cross_x, cross_y, input ready);
    modport sink (input valid, hit, cross_x, cross_y, output ready);
endinterface

/* src/sis_coef.sv */
module sis_coef #(
    parameter int COORD_BITS = sis_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    sis_seg_if.sink                       seg,
    input  logic                          down_en,
    output logic                          out_valid,
    output logic [2*COORD_BITS+2:0]       den_mag,
    output logic [3*COORD_BITS+2:0]       nx_mag,
    output logic [3*COORD_BITS+2:0]       ny_mag,
    output logic                          neg_x,
    output logic                          neg_y,
    output logic                          det_zero,
    output logic [8*COORD_BITS-1:0]       coords
);
    localparam int C  = COORD_BITS;
    localparam int AW = C + 1;
    localparam int PW = 2 * C;
    localparam int BW = 2 * C + 1;
    localparam int MW = 2 * C + 2;
    localparam int DW = 2 * C + 3;
    localparam int QW = 3 * C + 2;
    localparam int NW = 3 * C + 3;

    logic [4:0] en;
    logic [3:0] v_reg;

    logic [8*C-1:0] crd0;
    logic [8*C-1:0] crd1_reg, crd2_reg, crd3_reg, crd4_reg;

    logic signed [AW-1:0] s1_a_next[2], s1_c_next[2];
    logic signed [PW-1:0] s1_p_next[2], s1_q_next[2];
    logic                 s1_vt_next[2];
    logic signed [AW-1:0] s1_a_reg[2], s1_c_reg[2];
    logic signed [PW-1:0] s1_p_reg[2], s1_q_reg[2];
    logic                 s1_vt_reg[2];

    logic signed [AW-1:0] s2_a_next[2], s2_c_next[2];
    logic signed [BW-1:0] s2_b_next[2];
    logic signed [AW-1:0] s2_a_reg[2], s2_c_reg[2];
    logic signed [BW-1:0] s2_b_reg[2];

    logic signed [MW-1:0] m_ac0_reg, m_ac1_reg;
    logic signed [QW-1:0] m_bx0_reg, m_bx1_reg, m_by0_reg, m_by1_reg;

    logic signed [DW-1:0] d_w;
    logic signed [NW-1:0] nx_w, ny_w;

    assign crd0 = {seg.seg2_end_y, seg.seg2_end_x, seg.seg2_start_y, seg.seg2_start_x,
                   seg.seg1_end_y, seg.seg1_end_x, seg.seg1_start_y, seg.seg1_start_x};

    always_comb
    begin
        en[4] = down_en;
        for (int i = 3; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end
    assign seg.ready = en[0];
    assign out_valid = v_reg[3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0]) v_reg[0] <= seg.valid;
            for (int i = 1; i < 4; i++)
            begin
                if (en[i]) v_reg[i] <= v_reg[i-1];
            end
        end
    end

    // stage 1: differences and the two cross products of each segment
    always_comb
    begin
        logic signed [C-1:0] x1, y1, x2, y2;
        for (int j = 0; j < 2; j++)
        begin
            x1 = crd0[(4*j+0)*C +: C];
            y1 = crd0[(4*j+1)*C +: C];
            x2 = crd0[(4*j+2)*C +: C];
            y2 = crd0[(4*j+3)*C +: C];
            s1_a_next[j]  = {y2[C-1], y2} - {y1[C-1], y1};
            s1_c_next[j]  = {x2[C-1], x2} - {x1[C-1], x1};
            s1_p_next[j]  = y1 * x2;
            s1_q_next[j]  = x1 * y2;
            s1_vt_next[j] = (x1 == x2);
        end
    end

    // stage 2: line coefficients, vertical lines get a=1 b=-x1 c=0
    always_comb
    begin
        logic signed [C-1:0] x1;
        for (int j = 0; j < 2; j++)
        begin
            x1 = crd1_reg[(4*j)*C +: C];
            if (s1_vt_reg[j])
            begin
                s2_a_next[j] = {{(AW-1){1'b0}}, 1'b1};
                s2_c_next[j] = '0;
                s2_b_next[j] = -{{(BW-C){x1[C-1]}}, x1};
            end
            else
            begin
                s2_a_next[j] = s1_a_reg[j];
                s2_c_next[j] = s1_c_reg[j];
                s2_b_next[j] = {s1_p_reg[j][PW-1], s1_p_reg[j]}
                             - {s1_q_reg[j][PW-1], s1_q_reg[j]};
            end
        end
    end

    // stage 4: determinant and numerators, split into sign and magnitude
    assign d_w  = {m_ac0_reg[MW-1], m_ac0_reg} - {m_ac1_reg[MW-1], m_ac1_reg};
    assign nx_w = {m_bx0_reg[QW-1], m_bx0_reg} - {m_bx1_reg[QW-1], m_bx1_reg};
    assign ny_w = {m_by0_reg[QW-1], m_by0_reg} - {m_by1_reg[QW-1], m_by1_reg};

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            crd1_reg <= crd0;
            for (int j = 0; j < 2; j++)
            begin
                s1_a_reg[j]  <= s1_a_next[j];
                s1_c_reg[j]  <= s1_c_next[j];
                s1_p_reg[j]  <= s1_p_next[j];
                s1_q_reg[j]  <= s1_q_next[j];
                s1_vt_reg[j] <= s1_vt_next[j];
            end
        end
        if (en[1])
        begin
            crd2_reg <= crd1_reg;
            for (int j = 0; j < 2; j++)
            begin
                s2_a_reg[j] <= s2_a_next[j];
                s2_b_reg[j] <= s2_b_next[j];
                s2_c_reg[j] <= s2_c_next[j];
            end
        end
        if (en[2])
        begin
            crd3_reg  <= crd2_reg;
            m_ac0_reg <= s2_a_reg[1] * s2_c_reg[0];
            m_ac1_reg <= s2_a_reg[0] * s2_c_reg[1];
            m_bx0_reg <= s2_b_reg[0] * s2_c_reg[1];
            m_bx1_reg <= s2_c_reg[0] * s2_b_reg[1];
            m_by0_reg <= s2_a_reg[1] * s2_b_reg[0];
            m_by1_reg <= s2_a_reg[0] * s2_b_reg[1];
        end
        if (en[3])
        begin
            crd4_reg <= crd3_reg;
            den_mag  <= d_w[DW-1] ? -d_w : d_w;
            nx_mag   <= nx_w[NW-1] ? -nx_w : nx_w;
            ny_mag   <= ny_w[NW-1] ? -ny_w : ny_w;
            neg_x    <= nx_w[NW-1] ^ d_w[DW-1];
            neg_y    <= ny_w[NW-1] ^ d_w[DW-1];
            det_zero <= (d_w == '0);
        end
    end

    assign coords = crd4_reg;
endmodule

/* src/sis_div_stage.sv */
module sis_div_stage #(
    parameter int MW = 35,
    parameter int N  = 67
) (
    input  logic          clk,
    input  logic          en,
    input  logic [MW-1:0] ud,
    input  logic [MW-1:0] r_in,
    input  logic [N-1:0]  q_in,
    output logic [MW-1:0] r_reg,
    output logic [N-1:0]  q_reg
);
    logic [MW:0]   t;
    logic          ge;
    logic [MW:0]   diff;
    logic [MW-1:0] r_next;

    // one restoring step: next dividend bit shifts out, quotient bit shifts in
    assign t      = {r_in, q_in[N-1]};
    assign diff   = t - {1'b0, ud};
    assign ge     = (t >= {1'b0, ud});
    assign r_next = ge ? diff[MW-1:0] : t[MW-1:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg <= r_next;
            q_reg <= {q_in[N-2:0], ge};
        end
    end
endmodule

/* src/segment_intersection.sv */
// channel | modport | transaction payload
// seg     | sink    | two segments, four endpoints as eight signed COORD_BITS coordinates
// isect   | source  | hit, cross_x, cross_y in signed 32-bit fixed point
//
// one transaction per cycle sustained while isect.ready stays high; the quotient is
// computed in a divider chain that takes one divider stage per bit
// asynchronous active-low reset clears only the valid bits
// a stage advances when empty or when the stage after it advances, so stalls fill bubbles
module segment_intersection #(
    parameter int COORD_BITS = sis_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = sis_pkg::FRAC_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    sis_seg_if.sink    seg,
    sis_cross_if.source isect
);
`include "segment_intersection_assert.svh"
    localparam int C  = COORD_BITS;
    localparam int OB = sis_pkg::OUT_BITS;
    localparam int MW = 2 * C + 3;
    localparam int NW = 3 * C + 3;
    localparam int N  = NW + FRAC_BITS;
    localparam int SW = MW + 3 + 8 * C;
    localparam int XW = (N + 1 > OB + 1) ? N + 1 : OB + 1;

    logic          cf_valid;
    logic [MW-1:0] cf_den;
    logic [NW-1:0] cf_nx, cf_ny;
    logic          cf_neg_x, cf_neg_y, cf_dz;
    logic [8*C-1:0] cf_crd;

    logic [N:0]    en;
    logic          en_out;
    logic [N-1:0]  v_reg;
    logic [SW-1:0] side_reg[N];
    logic [SW-1:0] side0;

    logic [MW-1:0] rx[N+1], ry[N+1];
    logic [N-1:0]  qx[N+1], qy[N+1];

    logic          out_valid_reg, out_hit_reg, out_dz_reg;
    logic [OB-1:0] out_x_reg, out_y_reg;

    sis_coef #(.COORD_BITS(C)) u_coef (
        .clk      (clk),
        .rst_n    (rst_n),
        .seg      (seg),
        .down_en  (en[0]),
        .out_valid(cf_valid),
        .den_mag  (cf_den),
        .nx_mag   (cf_nx),
        .ny_mag   (cf_ny),
        .neg_x    (cf_neg_x),
        .neg_y    (cf_neg_y),
        .det_zero (cf_dz),
        .coords   (cf_crd)
    );

    assign side0 = {cf_den, cf_neg_x, cf_neg_y, cf_dz, cf_crd};
    assign rx[0] = '0;
    assign ry[0] = '0;
    assign qx[0] = N'(cf_nx) << FRAC_BITS;
    assign qy[0] = N'(cf_ny) << FRAC_BITS;

    assign en_out = !out_valid_reg || isect.ready;
    always_comb
    begin
        en[N] = en_out;
        for (int i = N - 1; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    for (genvar k = 0; k < N; k++)
    begin : g_div
        logic [MW-1:0] ud;
        if (k == 0)
        begin : g_first
            assign ud = cf_den;
        end
        else
        begin : g_rest
            assign ud = side_reg[k-1][SW-1 -: MW];
        end
        sis_div_stage #(.MW(MW), .N(N)) u_x (
            .clk(clk), .en(en[k]), .ud(ud),
            .r_in(rx[k]), .q_in(qx[k]), .r_reg(rx[k+1]), .q_reg(qx[k+1])
        );
        sis_div_stage #(.MW(MW), .N(N)) u_y (
            .clk(clk), .en(en[k]), .ud(ud),
            .r_in(ry[k]), .q_in(qy[k]), .r_reg(ry[k+1]), .q_reg(qy[k+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en[0]) v_reg[0] <= cf_valid;
            for (int i = 1; i < N; i++)
            begin
                if (en[i]) v_reg[i] <= v_reg[i-1];
            end
            if (en_out) out_valid_reg <= v_reg[N-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0]) side_reg[0] <= side0;
        for (int i = 1; i < N; i++)
        begin
            if (en[i]) side_reg[i] <= side_reg[i-1];
        end
    end

    // final stage: signed quotients, membership test, saturation
    logic [SW-1:0]       sd;
    logic signed [N:0]   px, py;
    logic signed [XW-1:0] ex_x, ex_y;
    logic                hit_next;
    logic [OB-1:0]       x_next, y_next;

    localparam logic signed [XW-1:0] SMAX = {{(XW-OB+1){1'b0}}, {(OB-1){1'b1}}};
    localparam logic signed [XW-1:0] SMIN = {{(XW-OB+1){1'b1}}, {(OB-1){1'b0}}};

    function automatic logic signed [N:0] scale(input logic signed [C-1:0] v);
        logic signed [N:0] e;
        e = {{(N+1-C){v[C-1]}}, v};
        return e <<< FRAC_BITS;
    endfunction

    function automatic logic between(input logic signed [N:0] v,
                                     input logic signed [N:0] e1,
                                     input logic signed [N:0] e2);
        return (v >= e1 && v <= e2) || (v >= e2 && v <= e1);
    endfunction

    function automatic logic on_seg(input logic [4*C-1:0] s,
                                    input logic signed [N:0] vx,
                                    input logic signed [N:0] vy);
        logic signed [C-1:0] ax, ay, bx, by;
        ax = s[0 +: C];
        ay = s[C +: C];
        bx = s[2*C +: C];
        by = s[3*C +: C];
        if (ax == bx && vx == scale(ax))
            return between(vy, scale(ay), scale(by));
        return between(vx, scale(ax), scale(bx));
    endfunction

    always_comb
    begin
        sd   = side_reg[N-1];
        px   = sd[8*C+2] ? -$signed({1'b0, qx[N]}) : $signed({1'b0, qx[N]});
        py   = sd[8*C+1] ? -$signed({1'b0, qy[N]}) : $signed({1'b0, qy[N]});
        ex_x = XW'(px);
        ex_y = XW'(py);
        hit_next = on_seg(sd[4*C-1:0], px, py) && on_seg(sd[8*C-1:4*C], px, py);
        priority if (ex_x > SMAX) x_next = SMAX[OB-1:0];
        else if (ex_x < SMIN)     x_next = SMIN[OB-1:0];
        else                      x_next = ex_x[OB-1:0];
        priority if (ex_y > SMAX) y_next = SMAX[OB-1:0];
        else if (ex_y < SMIN)     y_next = SMIN[OB-1:0];
        else                      y_next = ex_y[OB-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en_out)
        begin
            out_dz_reg  <= sd[8*C];
            out_hit_reg <= hit_next && !sd[8*C];
            out_x_reg   <= sd[8*C] ? '0 : x_next;
            out_y_reg   <= sd[8*C] ? '0 : y_next;
        end
    end

    assign isect.valid   = out_valid_reg;
    assign isect.hit     = out_hit_reg;
    assign isect.cross_x = out_x_reg;
    assign isect.cross_y = out_y_reg;

    `SI_ASSERT_IMP(a_parallel_zero, clk, rst_n, isect.valid && out_dz_reg,
        !isect.hit && isect.cross_x == '0 && isect.cross_y == '0)
    `SI_ASSERT_NXT(a_div_hold, clk, rst_n, v_reg[0] && !en[0], v_reg[0])
    `SI_ASSERT_NXT(a_drain, clk, rst_n, v_reg[N-1] && en_out, isect.valid)
endmodule
